>>> hdl/lcc_pkg.sv
package lcc_pkg;

   localparam int CARD_WIDTH         = 64;
   localparam int BCD_DIGITS         = 20;
   localparam int BCD_WIDTH          = 4 * BCD_DIGITS;
   localparam int DD_STEPS_PER_STAGE = 8;
   localparam int DD_STAGES          = CARD_WIDTH / DD_STEPS_PER_STAGE;
   localparam int MAX_DIGITS_DEFAULT = 19;
   localparam int COUNT_WIDTH        = 5;
   localparam int SUM_WIDTH          = 8;

   localparam logic [1:0] CLASS_NONE   = 2'd0;
   localparam logic [1:0] CLASS_PFX5X  = 2'd1;
   localparam logic [1:0] CLASS_PFX3X  = 2'd2;
   localparam logic [1:0] CLASS_LEAD4  = 2'd3;

   typedef logic [3:0] digit_type;
   typedef digit_type [BCD_DIGITS-1:0] digit_array_type;

   typedef struct packed {
      logic [BCD_WIDTH-1:0]  bcd;
      logic [CARD_WIDTH-1:0] bin;
   } dd_type;

   // Eight double-dabble iterations: add three to every digit of five or more, then shift.
   function automatic dd_type dd_step8(input dd_type din);
      dd_type d;
      d = din;
      for (int s = 0; s < DD_STEPS_PER_STAGE; s++) begin
         for (int k = 0; k < BCD_DIGITS; k++) begin
            if (d.bcd[4*k +: 4] >= 4'd5) begin
               d.bcd[4*k +: 4] = d.bcd[4*k +: 4] + 4'd3;
            end
         end
         d = {d.bcd[BCD_WIDTH-2:0], d.bin, 1'b0};
      end
      return d;
   endfunction

   function automatic logic [3:0] mod10(input logic [SUM_WIDTH-1:0] v);
      logic [SUM_WIDTH-1:0] r;
      r = v;
      if (r >= 8'd160) r = r - 8'd160;
      if (r >= 8'd80)  r = r - 8'd80;
      if (r >= 8'd40)  r = r - 8'd40;
      if (r >= 8'd20)  r = r - 8'd20;
      if (r >= 8'd10)  r = r - 8'd10;
      return r[3:0];
   endfunction

endpackage

>>> hdl/luhn_card_number_check.sv
// Luhn mod-10 card number checker with prefix classification. One transaction per
// cycle is accepted while the pipeline is not held, and its results leave in order. The
// data passes through eleven register stages: eight stages of binary-to-decimal
// conversion (eight double-dabble shifts each), two stages forming the digit count,
// the Luhn sum and the checksum test, and the output register holding checksum and
// class. The whole pipeline holds while a result waits under rsp_stall. Numbers of
// MAX_DIGITS+1 digits or more report that count with checksum and class cleared.
module luhn_card_number_check #(
   parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lcc_pkg::CARD_WIDTH-1:0]  req_card_number,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_card_class,
   output logic                            rsp_checksum_ok,
   output logic [lcc_pkg::COUNT_WIDTH-1:0] rsp_digit_count
);
   import lcc_pkg::*;

   logic   advance;
   dd_type dd_ff [DD_STAGES];
   dd_type dd_in [DD_STAGES];
   logic   dd_vld_ff [DD_STAGES];

   logic                   l1_vld_ff, l2_vld_ff;
   logic [SUM_WIDTH-1:0]   l1_sum_lo_ff, l1_sum_hi_ff, l1_sum_lo_in, l1_sum_hi_in;
   logic [COUNT_WIDTH-1:0] l1_count_ff, l1_count_in, l2_count_ff;
   logic                   l1_ovf_ff, l1_ovf_in, l2_ovf_ff;
   digit_type              l1_hi_ff, l1_lo_ff, l1_hi_in, l1_lo_in, l2_hi_ff, l2_lo_ff;
   logic                   l2_ok_ff, l2_ok_in;

   logic [1:0]             rsp_class_ff, rsp_class_in;
   logic                   rsp_ok_ff, rsp_ok_in, rsp_valid_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;

   digit_array_type        digits;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      dd_in[0] = dd_step8({{BCD_WIDTH{1'b0}}, req_card_number});
      for (int s = 1; s < DD_STAGES; s++) begin
         dd_in[s] = dd_step8(dd_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DD_STAGES; s++) begin
            dd_ff[s] <= dd_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DD_STAGES; s++) begin
            dd_vld_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         dd_vld_ff[0] <= req_valid;
         for (int s = 1; s < DD_STAGES; s++) begin
            dd_vld_ff[s] <= dd_vld_ff[s-1];
         end
      end
   end

   assign digits = dd_ff[DD_STAGES-1].bcd;

   // Digit count, overflow, the two leading digits and the two halves of the Luhn sum.
   always_comb begin
      logic [COUNT_WIDTH-1:0] top;
      logic [COUNT_WIDTH-1:0] hi_idx;
      digit_type              m;
      top       = COUNT_WIDTH'(1);
      l1_ovf_in = 1'b0;
      for (int k = 0; k < BCD_DIGITS; k++) begin
         if (digits[k] != 4'd0) begin
            if (k >= MAX_DIGITS) begin
               l1_ovf_in = 1'b1;
            end else begin
               top = COUNT_WIDTH'(k + 1);
            end
         end
      end
      l1_count_in = l1_ovf_in ? COUNT_WIDTH'(MAX_DIGITS + 1) : top;
      hi_idx      = top - COUNT_WIDTH'(1);
      l1_hi_in    = digits[hi_idx];
      l1_lo_in    = (top >= COUNT_WIDTH'(2)) ? digits[hi_idx - COUNT_WIDTH'(1)] : 4'd0;
      l1_sum_lo_in = '0;
      l1_sum_hi_in = '0;
      for (int k = 0; k < BCD_DIGITS; k++) begin
         m = digits[k];
         if (k % 2 == 1) begin
            m = (digits[k] >= 4'd5) ? 4'((digits[k] << 1) - 4'd9) : 4'(digits[k] << 1);
         end
         if (k < BCD_DIGITS / 2) begin
            l1_sum_lo_in = l1_sum_lo_in + SUM_WIDTH'(m);
         end else begin
            l1_sum_hi_in = l1_sum_hi_in + SUM_WIDTH'(m);
         end
      end
   end

   assign l2_ok_in = (mod10(l1_sum_lo_ff + l1_sum_hi_ff) == 4'd0) && !l1_ovf_ff;

   always_comb begin
      rsp_ok_in    = l2_ok_ff;
      rsp_class_in = CLASS_NONE;
      if (l2_ok_ff) begin
         if (l2_count_ff == COUNT_WIDTH'(16) && l2_hi_ff == 4'd5 &&
             l2_lo_ff >= 4'd1 && l2_lo_ff <= 4'd5) begin
            rsp_class_in = CLASS_PFX5X;
         end else if (l2_count_ff == COUNT_WIDTH'(15) && l2_hi_ff == 4'd3 &&
                      (l2_lo_ff == 4'd4 || l2_lo_ff == 4'd7)) begin
            rsp_class_in = CLASS_PFX3X;
         end else if ((l2_count_ff == COUNT_WIDTH'(16) || l2_count_ff == COUNT_WIDTH'(13)) &&
                      l2_hi_ff == 4'd4) begin
            rsp_class_in = CLASS_LEAD4;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l1_sum_lo_ff <= l1_sum_lo_in;
         l1_sum_hi_ff <= l1_sum_hi_in;
         l1_count_ff  <= l1_count_in;
         l1_ovf_ff    <= l1_ovf_in;
         l1_hi_ff     <= l1_hi_in;
         l1_lo_ff     <= l1_lo_in;
         l2_ok_ff     <= l2_ok_in;
         l2_count_ff  <= l1_count_ff;
         l2_ovf_ff    <= l1_ovf_ff;
         l2_hi_ff     <= l1_hi_ff;
         l2_lo_ff     <= l1_lo_ff;
         rsp_ok_ff    <= rsp_ok_in;
         rsp_class_ff <= l2_ovf_ff ? CLASS_NONE : rsp_class_in;
         rsp_count_ff <= l2_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_vld_ff    <= 1'b0;
         l2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         l1_vld_ff    <= dd_vld_ff[DD_STAGES-1];
         l2_vld_ff    <= l1_vld_ff;
         rsp_valid_ff <= l2_vld_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_card_class  = rsp_class_ff;
   assign rsp_checksum_ok = rsp_ok_ff;
   assign rsp_digit_count = rsp_count_ff;

endmodule
